// File: rtl/vertex_table_nearest_search_unit_assert.svh
// assertion macros for the vertex table nearest search unit
// no dependencies; included by the top level only
`ifndef VERTEX_TABLE_NEAREST_SEARCH_UNIT_ASSERT_SVH
`define VERTEX_TABLE_NEAREST_SEARCH_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// clocked on clk_i, quiet while rst_ni is low
`define VTNS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("vtns assertion failed");
// clocked on clk_i, also checked during reset
`define VTNS_ASSERT_NORST(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("vtns assertion failed during reset");
`else
`define VTNS_ASSERT(lbl, prop)
`define VTNS_ASSERT_NORST(lbl, prop)
`endif

`endif

// File: rtl/vtns_pkg.sv
// shared constants, codes and result type of the vertex table nearest search unit
// no dependencies
package vtns_pkg;

  localparam int unsigned MAX_VERTICES_DEF = 1024;

  localparam int unsigned CMD_W   = 2;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned IDX_W   = 10;
  localparam int unsigned COORD_W = 16;
  localparam int unsigned DIST_W  = 33;

  // one stored entry: {parent, y, x}
  localparam int unsigned ENTRY_W = IDX_W + 2 * COORD_W;

  // beat widths, padded to whole bytes
  localparam int unsigned S_DATA_W = 48;
  localparam int unsigned M_DATA_W = 88;

  // command codes
  localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

  // status codes
  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL      = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY     = 2'd2;
  localparam logic [STAT_W-1:0] STAT_UNWRITTEN = 2'd3;

  typedef struct packed {
    logic [STAT_W-1:0]         status;
    logic [IDX_W-1:0]          index;
    logic [IDX_W-1:0]          parent;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [DIST_W-1:0]         dist_sq;
  } res_t;

endpackage

// File: rtl/vtns_ram.sv
// generic simple dual-port ram: one write port, one read port, registered read
// no dependencies
module vtns_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/vertex_table_nearest_search_unit.sv
// vertex table with exhaustive nearest-vertex search, top level
// depends on vtns_pkg, vtns_ram and vertex_table_nearest_search_unit_assert.svh
//
// usage: one command per input beat on the s_axis side, one result beat on the
// m_axis side for append, search and read; command code 3 is swallowed silently.
// append stores {parent, y, x} at the next free slot (status full when no slot
// is left); search scans every stored vertex for the least squared distance,
// lowest index on a tie (status empty on an empty table); read returns a stored
// vertex by index (status unwritten at or above the fill count).
// throughput is one item at a time: the next beat is taken once the result sits
// in the output register; the search loop is bound by the single read port of
// the vertex memory, one vertex per cycle.
// the output register parts the two sides, so a stalled receiver holds only the
// finished result; a second finished result waits until the first is taken.
// reset clears the fill count and the handshake state; memory contents are not
// cleared and need no clearing pass, since only entries below the count are read.
`include "vertex_table_nearest_search_unit_assert.svh"

module vertex_table_nearest_search_unit #(
  parameter int unsigned MAX_VERTICES = vtns_pkg::MAX_VERTICES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // pos_x [15:0], pos_y [31:16], ref_index [41:32], zero pad [47:42]
  input  logic [vtns_pkg::S_DATA_W-1:0] s_axis_tdata_i,
  // cmd [1:0]
  input  logic [vtns_pkg::CMD_W-1:0]    s_axis_tuser_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // vertex_index [9:0], vertex_parent [19:10], vertex_x [35:20],
  // vertex_y [51:36], dist_sq [84:52], zero pad [87:85]
  output logic [vtns_pkg::M_DATA_W-1:0] m_axis_tdata_o,
  // status [1:0]
  output logic [vtns_pkg::STAT_W-1:0]   m_axis_tuser_o
);

  localparam int unsigned AW    = $clog2(MAX_VERTICES);
  localparam int unsigned CW    = $clog2(MAX_VERTICES + 1);
  localparam int unsigned CMPW  = (CW > vtns_pkg::IDX_W) ? CW : vtns_pkg::IDX_W;
  localparam int unsigned CW_   = vtns_pkg::COORD_W;
  localparam int unsigned DW    = vtns_pkg::DIST_W;
  localparam int unsigned IW    = vtns_pkg::IDX_W;
  localparam int unsigned EW    = vtns_pkg::ENTRY_W;
  localparam int unsigned PAD_W = vtns_pkg::M_DATA_W - (2 * IW + 2 * CW_ + DW);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SCAN,
    S_EMIT
  } state_e;

  // input beat fields
  logic [vtns_pkg::CMD_W-1:0] in_cmd;
  logic signed [CW_-1:0]      in_x;
  logic signed [CW_-1:0]      in_y;
  logic [IW-1:0]              in_ref;

  assign in_cmd = s_axis_tuser_i;
  assign in_x   = signed'(s_axis_tdata_i[CW_-1:0]);
  assign in_y   = signed'(s_axis_tdata_i[2*CW_-1:CW_]);
  assign in_ref = s_axis_tdata_i[2*CW_+IW-1:2*CW_];

  // control state
  state_e         state_q;
  logic [CW-1:0]  count_q;    // stored vertices
  logic [CW-1:0]  rd_idx_q;   // next index the scan reads
  logic           rv_q;       // memory read data valid this cycle (scan)
  logic [CW-1:0]  ridx1_q;    // index of that read data
  logic           p1v_q;      // squares stage valid
  logic           found_q;    // best holds a candidate
  logic           m_valid_q;

  // payload
  logic signed [CW_-1:0] qx_q, qy_q;
  logic [DW-1:0]         p1_sqx_q, p1_sqy_q;
  logic [EW-1:0]         p1_ent_q;
  logic [CW-1:0]         p1_idx_q;
  logic [DW-1:0]         best_d_q;
  logic [EW-1:0]         best_ent_q;
  logic [CW-1:0]         best_idx_q;
  vtns_pkg::res_t        res_q;     // finished result waiting for the output register
  vtns_pkg::res_t        out_q;

  logic accept;
  logic out_free;
  logic emit;
  logic is_full;
  logic read_ok;
  logic scan_issue;
  logic scan_done;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !m_valid_q || m_axis_tready_i;
  assign emit            = (state_q == S_EMIT) && out_free;
  assign is_full         = (count_q == CW'(MAX_VERTICES));
  assign read_ok         = (CMPW'(in_ref) < CMPW'(count_q));
  assign scan_issue      = (state_q == S_SCAN) && (rd_idx_q < count_q);
  assign scan_done       = (state_q == S_SCAN) && (rd_idx_q == count_q) && !rv_q && !p1v_q;

  // vertex memory: writes only at an append accept, reads only for read and
  // search, which never share a cycle with a write, so no forwarding is needed
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [EW-1:0] ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [EW-1:0] ram_rdata;

  assign ram_we    = accept && (in_cmd == vtns_pkg::CMD_APPEND) && !is_full;
  assign ram_waddr = count_q[AW-1:0];
  assign ram_wdata = {in_ref, in_y, in_x};
  assign ram_re    = (accept && (in_cmd == vtns_pkg::CMD_READ) && read_ok) || scan_issue;
  assign ram_raddr = (state_q == S_IDLE) ? AW'(in_ref) : rd_idx_q[AW-1:0];

  vtns_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_VERTICES)
  ) u_vertex_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // entry fields as read
  logic signed [CW_-1:0] rd_x, rd_y;
  logic [IW-1:0]         rd_par;

  assign rd_x   = signed'(ram_rdata[CW_-1:0]);
  assign rd_y   = signed'(ram_rdata[2*CW_-1:CW_]);
  assign rd_par = ram_rdata[EW-1:2*CW_];

  // squares stage: one 17x17 multiplier per axis
  logic signed [CW_:0]     dx, dy;
  logic signed [2*CW_+1:0] sqx_full, sqy_full;

  assign dx       = {rd_x[CW_-1], rd_x} - {qx_q[CW_-1], qx_q};
  assign dy       = {rd_y[CW_-1], rd_y} - {qy_q[CW_-1], qy_q};
  assign sqx_full = dx * dx;
  assign sqy_full = dy * dy;

  // compare stage: sum cannot overflow 33 bits
  logic [DW-1:0] sum_d;
  logic          take;

  assign sum_d = p1_sqx_q + p1_sqy_q;
  assign take  = !found_q || (sum_d < best_d_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      rd_idx_q  <= '0;
      rv_q      <= 1'b0;
      p1v_q     <= 1'b0;
      found_q   <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      rv_q  <= scan_issue;
      p1v_q <= rv_q;
      // a new result may replace the one taken in the same cycle
      if (emit) begin
        m_valid_q <= 1'b1;
      end else if (m_valid_q && m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end

      // scan pipeline
      if (scan_issue) begin
        rd_idx_q <= rd_idx_q + CW'(1);
      end
      ridx1_q <= rd_idx_q;
      if (rv_q) begin
        p1_sqx_q <= sqx_full[DW-1:0];
        p1_sqy_q <= sqy_full[DW-1:0];
        p1_ent_q <= ram_rdata;
        p1_idx_q <= ridx1_q;
      end
      if (p1v_q && take) begin
        found_q    <= 1'b1;
        best_d_q   <= sum_d;
        best_ent_q <= p1_ent_q;
        best_idx_q <= p1_idx_q;
      end

      case (state_q)
        S_IDLE: begin
          if (accept) begin
            case (in_cmd)
              vtns_pkg::CMD_APPEND: begin
                res_q.dist_sq <= '0;
                if (is_full) begin
                  res_q.status <= vtns_pkg::STAT_FULL;
                  res_q.index  <= '0;
                  res_q.parent <= '0;
                  res_q.x      <= '0;
                  res_q.y      <= '0;
                end else begin
                  res_q.status <= vtns_pkg::STAT_OK;
                  res_q.index  <= IW'(count_q);
                  res_q.parent <= in_ref;
                  res_q.x      <= in_x;
                  res_q.y      <= in_y;
                  count_q      <= count_q + CW'(1);
                end
                state_q <= S_EMIT;
              end
              vtns_pkg::CMD_SEARCH: begin
                if (count_q == '0) begin
                  res_q.status  <= vtns_pkg::STAT_EMPTY;
                  res_q.index   <= '0;
                  res_q.parent  <= '0;
                  res_q.x       <= '0;
                  res_q.y       <= '0;
                  res_q.dist_sq <= '0;
                  state_q       <= S_EMIT;
                end else begin
                  qx_q     <= in_x;
                  qy_q     <= in_y;
                  rd_idx_q <= '0;
                  found_q  <= 1'b0;
                  state_q  <= S_SCAN;
                end
              end
              vtns_pkg::CMD_READ: begin
                res_q.index   <= in_ref;
                res_q.dist_sq <= '0;
                if (read_ok) begin
                  state_q <= S_READ;
                end else begin
                  res_q.status <= vtns_pkg::STAT_UNWRITTEN;
                  res_q.parent <= '0;
                  res_q.x      <= '0;
                  res_q.y      <= '0;
                  state_q      <= S_EMIT;
                end
              end
              default: begin
                state_q <= S_IDLE;  // unused command: no result
              end
            endcase
          end
        end
        S_READ: begin
          res_q.status <= vtns_pkg::STAT_OK;
          res_q.parent <= rd_par;
          res_q.x      <= rd_x;
          res_q.y      <= rd_y;
          state_q      <= S_EMIT;
        end
        S_SCAN: begin
          if (scan_done) begin
            res_q.status  <= vtns_pkg::STAT_OK;
            res_q.index   <= IW'(best_idx_q);
            res_q.parent  <= best_ent_q[EW-1:2*CW_];
            res_q.x       <= signed'(best_ent_q[CW_-1:0]);
            res_q.y       <= signed'(best_ent_q[2*CW_-1:CW_]);
            res_q.dist_sq <= best_d_q;
            state_q       <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit) begin
            out_q   <= res_q;
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tuser_o  = out_q.status;
  assign m_axis_tdata_o  = {{PAD_W{1'b0}}, out_q.dist_sq, out_q.y, out_q.x,
                            out_q.parent, out_q.index};

  // fill count never passes the table depth
  `VTNS_ASSERT(a_count_bound, count_q <= CW'(MAX_VERTICES))
  // scan pipeline is only busy inside a search
  `VTNS_ASSERT(a_pipe_in_scan, (rv_q || p1v_q) |-> (state_q == S_SCAN))
  // a good result always names a vertex below the fill count
  `VTNS_ASSERT(a_ok_index_stored, (m_valid_q && (out_q.status == vtns_pkg::STAT_OK)) |-> (CMPW'(out_q.index) < CMPW'(count_q)))
  // reset leaves the block idle with no result showing
  `VTNS_ASSERT_NORST(a_rst_quiet, !rst_ni |=> (!m_axis_tvalid_o && (state_q == S_IDLE)))

endmodule
